// ===== rtl/xcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfd_pkg
// Shared types and constants for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 128;
   localparam int HEADER_BYTES        = 8;
   localparam int CAPTURE_BYTES       = 12;

   localparam logic [7:0] START_BYTE_RESET    = 8'h01;
   localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd128;

   // Configuration register indexes
   localparam logic CSR_START_BYTE    = 1'b0;
   localparam logic CSR_PAYLOAD_LIMIT = 1'b1;

   // Frame status codes; the first three also index the event counters
   localparam logic [1:0] STATUS_VALID      = 2'd0;
   localparam logic [1:0] STATUS_HEADER_BAD = 2'd1;
   localparam logic [1:0] STATUS_DATA_BAD   = 2'd2;
   localparam logic [1:0] STATUS_LENGTH_REJ = 2'd3;
   localparam logic [1:0] COUNT_STARTS      = 2'd3;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [15:0] frame_id;
      logic [15:0] frame_kind;
      logic [15:0] payload_length;
      logic [31:0] payload_word0;
      logic [31:0] payload_word1;
      logic [31:0] payload_word2;
      logic [31:0] good_frames;
      logic [31:0] header_fails;
      logic [31:0] data_fails;
      logic [31:0] starts_seen;
   } result_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] payload_limit;
   } config_type;

endpackage

// ===== rtl/xcfd_engine.sv =====
// ----------------------------------------------------------------------------
// xcfd_engine
// Frame state, header store, running XOR, payload capture and event counters.
// Processes one accepted transaction per cycle and raises push when a frame completes or its length is rejected.
// ----------------------------------------------------------------------------
module xcfd_engine #(
   parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  xcfd_pkg::config_type   cfg,
   input  logic                   in_accept,
   input  logic                   in_type,
   input  logic [7:0]             in_byte,
   output logic                   push_valid,
   output xcfd_pkg::result_type   push_data
);

   localparam logic [7:0] MaxLimit = 8'(MAX_PAYLOAD);
   localparam int HdrStore = xcfd_pkg::HEADER_BYTES - 1;

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  xor_ff, xor_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [31:0] cap_ff [3];
   logic [31:0] cap_in [3];
   logic [31:0] cnt_ff [4];
   logic [31:0] cnt_in [4];
   logic [7:0]  hdr_ff [HdrStore];

   logic [7:0]  limit;
   logic [15:0] len;
   logic [7:0]  hdr_x;
   logic        hok_now;
   logic        hdr_we;
   logic [1:0]  st;
   logic        push;

   assign limit   = (cfg.payload_limit > MaxLimit) ? MaxLimit : cfg.payload_limit;
   assign len     = {hdr_ff[3], hdr_ff[4]};
   assign hdr_x   = hdr_ff[0] ^ hdr_ff[1] ^ hdr_ff[2] ^ hdr_ff[3]
                  ^ hdr_ff[4] ^ hdr_ff[5] ^ hdr_ff[6];
   assign hok_now = (in_byte == ~hdr_x);

   always_comb begin
      pos_in    = pos_ff;
      total_in  = total_ff;
      xor_in    = xor_ff;
      hdr_ok_in = hdr_ok_ff;
      cap_in    = cap_ff;
      cnt_in    = cnt_ff;
      hdr_we    = 1'b0;
      st        = xcfd_pkg::STATUS_VALID;
      push      = 1'b0;
      if (in_accept) begin
         if (in_type) begin
            pos_in   = '0;
            total_in = '0;
            xor_in   = '0;
            cap_in   = '{default: '0};
         end else if (total_ff == '0) begin
            if (pos_ff != '0 || in_byte == cfg.start_byte) begin
               if (pos_ff == '0) begin
                  cnt_in[xcfd_pkg::COUNT_STARTS] = cnt_ff[xcfd_pkg::COUNT_STARTS] + 32'd1;
                  xor_in = '0;
                  cap_in = '{default: '0};
               end
               hdr_we = (pos_ff < 8'(HdrStore));
               pos_in = pos_ff + 8'd1;
               if (pos_ff == 8'(HdrStore)) begin
                  // header complete
                  pos_in    = '0;
                  xor_in    = '0;
                  hdr_ok_in = hok_now;
                  if (len > {8'd0, limit}) begin
                     st     = xcfd_pkg::STATUS_LENGTH_REJ;
                     push   = 1'b1;
                     cap_in = '{default: '0};
                  end else if (len == '0) begin
                     st         = hok_now ? xcfd_pkg::STATUS_VALID
                                          : xcfd_pkg::STATUS_HEADER_BAD;
                     cnt_in[st] = cnt_ff[st] + 32'd1;
                     push       = 1'b1;
                     cap_in     = '{default: '0};
                  end else begin
                     total_in = len[7:0];
                  end
               end
            end
         end else if (pos_ff < total_ff) begin
            if (pos_ff < 8'(xcfd_pkg::CAPTURE_BYTES)) begin
               cap_in[pos_ff[3:2]][{pos_ff[1:0], 3'b000} +: 8] =
                  cap_ff[pos_ff[3:2]][{pos_ff[1:0], 3'b000} +: 8] | in_byte;
            end
            xor_in = xor_ff ^ in_byte;
            pos_in = pos_ff + 8'd1;
         end else begin
            // data check byte
            if (!hdr_ok_ff) begin
               st = xcfd_pkg::STATUS_HEADER_BAD;
            end else if (in_byte != ~xor_ff) begin
               st = xcfd_pkg::STATUS_DATA_BAD;
            end else begin
               st = xcfd_pkg::STATUS_VALID;
            end
            cnt_in[st] = cnt_ff[st] + 32'd1;
            push       = 1'b1;
            pos_in     = '0;
            total_in   = '0;
            xor_in     = '0;
            cap_in     = '{default: '0};
         end
      end
   end

   always_comb begin
      push_valid                = push;
      push_data.frame_status    = st;
      push_data.frame_id        = {hdr_ff[1], hdr_ff[2]};
      push_data.frame_kind      = {hdr_ff[5], hdr_ff[6]};
      push_data.payload_length  = len;
      push_data.payload_word0   = (st == xcfd_pkg::STATUS_LENGTH_REJ) ? '0 : cap_ff[0];
      push_data.payload_word1   = (st == xcfd_pkg::STATUS_LENGTH_REJ) ? '0 : cap_ff[1];
      push_data.payload_word2   = (st == xcfd_pkg::STATUS_LENGTH_REJ) ? '0 : cap_ff[2];
      push_data.good_frames     = cnt_in[xcfd_pkg::STATUS_VALID];
      push_data.header_fails    = cnt_in[xcfd_pkg::STATUS_HEADER_BAD];
      push_data.data_fails      = cnt_in[xcfd_pkg::STATUS_DATA_BAD];
      push_data.starts_seen     = cnt_in[xcfd_pkg::COUNT_STARTS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         total_ff  <= '0;
         xor_ff    <= '0;
         hdr_ok_ff <= 1'b0;
         cap_ff    <= '{default: '0};
         cnt_ff    <= '{default: '0};
      end else begin
         pos_ff    <= pos_in;
         total_ff  <= total_in;
         xor_ff    <= xor_in;
         hdr_ok_ff <= hdr_ok_in;
         cap_ff    <= cap_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[pos_ff[2:0]] <= in_byte;
      end
   end

`ifndef SYNTHESIS
   a_header_pos: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) |-> (pos_ff < 8'(xcfd_pkg::HEADER_BYTES)))
      else $error("header position out of range");

   a_payload_pos: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> (pos_ff <= total_ff && total_ff <= MaxLimit))
      else $error("payload position beyond frame length");

   a_resync_clear: assert property (@(posedge clock) disable iff (reset)
      (in_accept && in_type) |=> (pos_ff == '0 && total_ff == '0 && xor_ff == '0))
      else $error("resync did not clear frame state");
`endif

endmodule

// ===== rtl/xcfd_out_buffer.sv =====
// ----------------------------------------------------------------------------
// xcfd_out_buffer
// Result register with a skid stage; full tells the engine to stall input.
// ----------------------------------------------------------------------------
module xcfd_out_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  xcfd_pkg::result_type   push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output xcfd_pkg::result_type   rsp_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   xcfd_pkg::result_type out_data_ff, out_data_in;
   xcfd_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop       = out_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push_valid;
            skid_data_in  = push_data;
         end else begin
            out_valid_in  = push_valid;
            out_data_in   = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_valid_ff && rsp_stall) |-> !push_valid)
      else $error("result pushed into a full buffer");
`endif

endmodule

// ===== rtl/xor_checked_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_core
// Byte-serial frame deframer with inverted-XOR header and data checks.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the req channel while not stalled;
// each byte updates the position, running XOR and capture registers in the
// engine. A frame (start byte, id, length, type, header check, payload, data
// check) yields one rsp transaction, held in the result register or skid
// stage after its last byte; oversized frames are reported with the length
// status right after the header. A result register and skid stage let input
// continue while a result waits; req_stall rises only when both hold one.
// Write csr registers (0 start byte, 1 payload limit) only while idle.
module xor_checked_frame_deframer_core #(
   parameter int MAX_PAYLOAD = xcfd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_status,
   output logic [15:0] rsp_frame_id,
   output logic [15:0] rsp_frame_kind,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_payload_word0,
   output logic [31:0] rsp_payload_word1,
   output logic [31:0] rsp_payload_word2,
   output logic [31:0] rsp_good_frames,
   output logic [31:0] rsp_header_fails,
   output logic [31:0] rsp_data_fails,
   output logic [31:0] rsp_starts_seen
);

   xcfd_pkg::config_type cfg_ff, cfg_in;
   xcfd_pkg::result_type push_data;
   xcfd_pkg::result_type rsp_data;
   logic                 push_valid;
   logic                 full;
   logic                 in_accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            xcfd_pkg::CSR_START_BYTE:    cfg_in.start_byte    = csr_write_data;
            xcfd_pkg::CSR_PAYLOAD_LIMIT: cfg_in.payload_limit = csr_write_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= xcfd_pkg::START_BYTE_RESET;
         cfg_ff.payload_limit <= xcfd_pkg::PAYLOAD_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;
   assign in_accept = req_valid && !full;

   xcfd_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_accept  (in_accept),
      .in_type    (req_type),
      .in_byte    (req_rx_byte),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   xcfd_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_frame_status   = rsp_data.frame_status;
   assign rsp_frame_id       = rsp_data.frame_id;
   assign rsp_frame_kind     = rsp_data.frame_kind;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_payload_word0  = rsp_data.payload_word0;
   assign rsp_payload_word1  = rsp_data.payload_word1;
   assign rsp_payload_word2  = rsp_data.payload_word2;
   assign rsp_good_frames    = rsp_data.good_frames;
   assign rsp_header_fails   = rsp_data.header_fails;
   assign rsp_data_fails     = rsp_data.data_fails;
   assign rsp_starts_seen    = rsp_data.starts_seen;

endmodule
